// ===== src/tadvp_pkg.sv =====
// Shared types and constants for the three-axis deceleration velocity profile.
// No dependencies; imported by tadvp_sqrt and the top level.
package tadvp_pkg;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQX,
    ST_SQY,
    ST_ARRIVE,
    ST_MULA,
    ST_SQST,
    ST_SQWT,
    ST_STEP,
    ST_CLMP,
    ST_DONE
  } state_t;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_MOVING  = 2'd0;
  localparam status_t STAT_ARRIVED = 2'd1;
  localparam status_t STAT_ABORTED = 2'd2;

  // Axis codes
  typedef logic [1:0] axis_t;
  localparam axis_t AX_X = 2'd0;
  localparam axis_t AX_Y = 2'd1;
  localparam axis_t AX_T = 2'd2;

  // Configuration register indexes
  localparam int CfgAddrW = 4;
  typedef logic [CfgAddrW-1:0] cfg_addr_t;
  localparam cfg_addr_t REG_X_LIM   = 4'd0;
  localparam cfg_addr_t REG_Y_LIM   = 4'd1;
  localparam cfg_addr_t REG_T_LIM   = 4'd2;
  localparam cfg_addr_t REG_X_ACC   = 4'd3;
  localparam cfg_addr_t REG_Y_ACC   = 4'd4;
  localparam cfg_addr_t REG_T_ACC   = 4'd5;
  localparam cfg_addr_t REG_LIN_TOL = 4'd6;
  localparam cfg_addr_t REG_ANG_TOL = 4'd7;

  // Register reset values
  localparam logic [31:0] LIM_RST     = 32'h0800_F800;
  localparam logic [15:0] ACC_RST     = 16'd4096;
  localparam logic [31:0] LIN_TOL_RST = 32'd655;
  localparam logic [19:0] ANG_TOL_RST = 20'd3277;

  // Square root: 30-bit radicand, 15-bit root, one root bit per cycle
  localparam int SqrtRadW  = 30;
  localparam int SqrtRootW = 15;
  localparam logic [SqrtRootW-1:0] ROOT_SAT = 15'h7FFF;

endpackage

// ===== src/tadvp_sqrt.sv =====
// Iterative restoring integer square root, one root bit per cycle.
// Depends on tadvp_pkg for the radicand and root widths.
module tadvp_sqrt import tadvp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [SqrtRadW-1:0]  radicand,
  output logic                 done,
  output logic [SqrtRootW-1:0] root
);

  localparam int CntW = $clog2(SqrtRootW);
  localparam logic [CntW-1:0] CNT_LAST = CntW'(SqrtRootW - 1);

  logic [SqrtRadW-1:0]  rad_r;
  logic [SqrtRootW:0]   rem_r;
  logic [SqrtRootW-1:0] root_r;
  logic [CntW-1:0]      cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [SqrtRootW+2:0] rem_sh;
  logic [SqrtRootW+2:0] trial;
  logic                 fits;

  // Bring down the next two radicand bits and try the next root bit
  assign rem_sh = {rem_r, rad_r[SqrtRadW-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath: remainder, partial root, radicand shifter
  // Remainder stays below 2*root + 1, so it needs one bit more than the root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[SqrtRadW-3:0], 2'b00};
      if (fits) begin
        rem_r  <= (SqrtRootW+1)'(rem_sh - trial);
        root_r <= {root_r[SqrtRootW-2:0], 1'b1};
      end else begin
        rem_r  <= (SqrtRootW+1)'(rem_sh);
        root_r <= {root_r[SqrtRootW-2:0], 1'b0};
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== src/three_axis_decel_velocity_profile.sv =====
// Top level: three-axis square-root deceleration velocity profile.
// Depends on tadvp_pkg and tadvp_sqrt (shared square root unit).
//
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tdata: diff_x, diff_y, yaw_offset, dt_ticks; tuser: new_goal
// out_     out  out_tvalid/out_tready tdata: vel_x, vel_y, vel_theta; tuser: status
// cfg_     in   cfg_we               cfg_addr, cfg_wdata
//
// An item is accepted in ST_IDLE, ST_SQX and ST_SQY square the offsets and ST_ARRIVE runs the
// arrival test; a moving item then runs ST_MULA, ST_SQST, ST_SQWT (bit-serial square root),
// ST_STEP and ST_CLMP per axis, and ST_DONE loads the result. The single 32x32 multiplier and the
// square root unit are shared by all three axes; arrival or abort results go from ST_ARRIVE to ST_DONE.
// in_tready is high only while the sequencer is idle. The result sits in an output register, so
// the next word is taken while a finished result waits on out_tready; a second result waits in
// the sequencer. Reset (synchronous, active low) clears the kept velocities and loads the
// register defaults.
module three_axis_decel_velocity_profile import tadvp_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  // input stream
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [103:0]    in_tdata,   // [31:0] diff_x, [63:32] diff_y, [82:64] yaw_offset,
                                      // [98:83] dt_ticks, [103:99] zero
  input  logic [0:0]      in_tuser,   // [0] new_goal
  // result stream
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [47:0]     out_tdata,  // [15:0] vel_x, [31:16] vel_y, [47:32] vel_theta
  output logic [1:0]      out_tuser,  // [1:0] status
  // configuration
  input  logic            cfg_we,
  input  cfg_addr_t       cfg_addr,
  input  logic [31:0]     cfg_wdata
);

  // Configuration registers
  logic [31:0] x_lim_r, y_lim_r, t_lim_r;
  logic [15:0] x_acc_r, y_acc_r, t_acc_r;
  logic [31:0] lin_tol_r;
  logic [19:0] ang_tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_lim_r   <= LIM_RST;
      y_lim_r   <= LIM_RST;
      t_lim_r   <= LIM_RST;
      x_acc_r   <= ACC_RST;
      y_acc_r   <= ACC_RST;
      t_acc_r   <= ACC_RST;
      lin_tol_r <= LIN_TOL_RST;
      ang_tol_r <= ANG_TOL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_X_LIM:   x_lim_r   <= cfg_wdata;
        REG_Y_LIM:   y_lim_r   <= cfg_wdata;
        REG_T_LIM:   t_lim_r   <= cfg_wdata;
        REG_X_ACC:   x_acc_r   <= cfg_wdata[15:0];
        REG_Y_ACC:   y_acc_r   <= cfg_wdata[15:0];
        REG_T_ACC:   t_acc_r   <= cfg_wdata[15:0];
        REG_LIN_TOL: lin_tol_r <= cfg_wdata;
        REG_ANG_TOL: ang_tol_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  // Input word unpacking
  logic signed [31:0] in_dx, in_dy;
  logic signed [18:0] in_dyaw;
  assign in_dx   = in_tdata[31:0];
  assign in_dy   = in_tdata[63:32];
  assign in_dyaw = in_tdata[82:64];

  // Sequencer state and control
  state_t state_r, state_nxt;
  axis_t  axis_r;
  logic   in_acc, mul_en, sq_start, out_load;
  logic   sq_done;
  logic [SqrtRootW-1:0] sq_root;

  // Per-item operands
  logic [31:0] mag_x_r, mag_y_r;
  logic [18:0] mag_t_r;
  logic        neg_x_r, neg_y_r, neg_t_r;
  logic [15:0] dt_r;

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_r, dist_r;

  // Per-axis working values
  logic signed [15:0] vel_r [0:2];
  logic               sat_r;
  logic signed [17:0] step_r;
  status_t            res_stat_r;

  // Output register
  logic        out_valid_r;
  logic [47:0] out_data_r;
  status_t     out_stat_r;

  // Axis selection
  logic [15:0]        sel_acc;
  logic [31:0]        sel_lim;
  logic [31:0]        sel_mag;
  logic               sel_neg;
  logic signed [15:0] sel_vel;

  always_comb begin
    unique case (axis_r)
      AX_X: begin
        sel_acc = x_acc_r; sel_lim = x_lim_r; sel_mag = mag_x_r;
        sel_neg = neg_x_r; sel_vel = vel_r[0];
      end
      AX_Y: begin
        sel_acc = y_acc_r; sel_lim = y_lim_r; sel_mag = mag_y_r;
        sel_neg = neg_y_r; sel_vel = vel_r[1];
      end
      default: begin
        sel_acc = t_acc_r; sel_lim = t_lim_r; sel_mag = {13'd0, mag_t_r};
        sel_neg = neg_t_r; sel_vel = vel_r[2];
      end
    endcase
  end

  // Arrival and abort tests
  logic [63:0] dist_sum;
  logic        arrived, acc_zero;
  assign dist_sum = dist_r + prod_r;
  assign arrived  = (dist_sum <= {lin_tol_r, 16'd0}) && ({1'b0, mag_t_r} <= ang_tol_r);
  assign acc_zero = (x_acc_r == '0) || (y_acc_r == '0) || (t_acc_r == '0);

  // Velocity step toward the target, bounded by accel*dt/65536
  logic [SqrtRootW-1:0] root_sel;
  logic signed [17:0]   target, delta, bound, step_c;
  assign root_sel = sat_r ? ROOT_SAT : sq_root;
  assign target   = sel_neg ? -$signed({3'b000, root_sel}) : $signed({3'b000, root_sel});
  assign delta    = target - 18'(sel_vel);
  assign bound    = $signed({2'b00, prod_r[31:16]});

  always_comb begin
    if (target > 18'(sel_vel)) begin
      step_c = (delta < bound) ? delta : bound;
    end else begin
      step_c = (delta > -bound) ? delta : -bound;
    end
  end

  // Clamp to the axis limits, max test first
  logic signed [17:0] new_sum;
  logic signed [15:0] new_vel, vmax, vmin, clamped;
  assign new_sum = 18'(sel_vel) + step_r;
  assign new_vel = new_sum[15:0];
  assign vmax    = sel_lim[31:16];
  assign vmin    = sel_lim[15:0];

  always_comb begin
    priority if (new_vel > vmax) begin
      clamped = vmax;
    end else if (new_vel < vmin) begin
      clamped = vmin;
    end else begin
      clamped = new_vel;
    end
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQX: begin
        mul_a = mag_x_r; mul_b = mag_x_r;
      end
      ST_SQY: begin
        mul_a = mag_y_r; mul_b = mag_y_r;
      end
      ST_MULA: begin
        mul_a = {16'd0, sel_acc}; mul_b = sel_mag;
      end
      ST_SQST: begin
        mul_a = {16'd0, sel_acc}; mul_b = {16'd0, dt_r};
      end
      default: ;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    in_acc    = 1'b0;
    mul_en    = 1'b0;
    sq_start  = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          in_acc    = 1'b1;
          state_nxt = ST_SQX;
        end
      end
      ST_SQX: begin
        mul_en    = 1'b1;
        state_nxt = ST_SQY;
      end
      ST_SQY: begin
        mul_en    = 1'b1;
        state_nxt = ST_ARRIVE;
      end
      ST_ARRIVE: begin
        if (acc_zero || arrived) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_MULA;
        end
      end
      ST_MULA: begin
        mul_en    = 1'b1;
        state_nxt = ST_SQST;
      end
      ST_SQST: begin
        mul_en    = 1'b1;
        sq_start  = 1'b1;
        state_nxt = ST_SQWT;
      end
      ST_SQWT: begin
        if (sq_done) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        state_nxt = ST_CLMP;
      end
      ST_CLMP: begin
        state_nxt = (axis_r == AX_T) ? ST_DONE : ST_MULA;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Kept velocities and axis counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vel_r[0] <= '0;
      vel_r[1] <= '0;
      vel_r[2] <= '0;
      axis_r   <= AX_X;
    end else begin
      if (in_acc) begin
        axis_r <= AX_X;
        if (in_tuser[0]) begin
          vel_r[0] <= '0;
          vel_r[1] <= '0;
          vel_r[2] <= '0;
        end
      end else if (state_r == ST_ARRIVE && !acc_zero && arrived) begin
        vel_r[0] <= '0;
        vel_r[1] <= '0;
        vel_r[2] <= '0;
      end else if (state_r == ST_CLMP) begin
        unique case (axis_r)
          AX_X:    vel_r[0] <= clamped;
          AX_Y:    vel_r[1] <= clamped;
          default: vel_r[2] <= clamped;
        endcase
        axis_r <= axis_r + 1'b1;
      end
    end
  end

  // Item capture and working registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_x_r <= in_dx[31];
      neg_y_r <= in_dy[31];
      neg_t_r <= in_dyaw[18];
      mag_x_r <= in_dx[31] ? 32'(-in_dx) : in_dx;
      mag_y_r <= in_dy[31] ? 32'(-in_dy) : in_dy;
      mag_t_r <= in_dyaw[18] ? 19'(-in_dyaw) : in_dyaw;
      dt_r    <= in_tdata[98:83];
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ST_SQY) begin
      dist_r <= prod_r;
    end
    // Root saturates once the radicand reaches 2^30
    if (state_r == ST_SQST) begin
      sat_r <= |prod_r[63:SqrtRadW+3];
    end
    if (state_r == ST_STEP) begin
      step_r <= step_c;
    end
    if (state_r == ST_ARRIVE) begin
      priority if (acc_zero) begin
        res_stat_r <= STAT_ABORTED;
      end else if (arrived) begin
        res_stat_r <= STAT_ARRIVED;
      end else begin
        res_stat_r <= STAT_MOVING;
      end
    end
  end

  // Shared square root unit; radicand is floor(2*accel*|offset|/16)
  tadvp_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (prod_r[SqrtRadW+2:3]),
    .done     (sq_done),
    .root     (sq_root)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_stat_r <= res_stat_r;
      if (res_stat_r == STAT_MOVING) begin
        out_data_r <= {vel_r[2], vel_r[1], vel_r[0]};
      end else begin
        out_data_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_stat_r;

endmodule
